/* hdl/ckc_pkg.sv */
// Package for the color key centroid block: widths, limits, controller
// states, command struct and register indexes. No dependencies.
package ckc_pkg;

  localparam int COLOR_W = 8;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 25;
  localparam int SUM_W   = 37;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Largest frame edge; a coordinate at or above it never counts as a hit.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 15;
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

  // Hit counting saturates at the smaller of MAX_DIM squared and the count range.
  localparam longint unsigned DIM_SQ  = longint'(MAX_DIM) * longint'(MAX_DIM);
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'((DIM_SQ < CNT_MAX) ? DIM_SQ : CNT_MAX);

  // The mean never exceeds a coordinate, so the quotient has POS_W bits.
  localparam int DIV_STEPS = POS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_KEY_RED   = 2'd0,
    REG_KEY_GREEN = 2'd1,
    REG_KEY_BLUE  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_WAIT_OUT
  } state_t;

  typedef struct packed {
    logic acc;       // pixel transfer: update accumulators
    logic load;      // last pixel: hand totals to the divider, clear accumulators
    logic step;      // one quotient bit
    logic out_load;  // capture the result into the output register
  } ckc_cmd_t;

endpackage

/* hdl/ckc_ctrl.sv */
// Controller for the color key centroid block: handshakes, divide step
// counter and output valid. Depends on ckc_pkg.
module ckc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_frame_end,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output ckc_pkg::ckc_cmd_t cmd
);

  ckc_pkg::state_t              state_r, state_nxt;
  logic [ckc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ckc_pkg::ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ckc_pkg::ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_frame_end) begin
            cmd.load  = 1'b1;
            step_nxt  = '0;
            state_nxt = ckc_pkg::ST_DIVIDE;
          end
        end
      end
      ckc_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == ckc_pkg::STEP_W'(ckc_pkg::DIV_STEPS - 1)) begin
          state_nxt = ckc_pkg::ST_WAIT_OUT;
        end
      end
      ckc_pkg::ST_WAIT_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ckc_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ckc_pkg::ST_ACCUM;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/ckc_dp.sv */
// Datapath for the color key centroid block: key match, accumulators,
// two restoring dividers and the output register. Depends on ckc_pkg.
module ckc_dp (
  input  logic                         clk,
  input  ckc_pkg::ckc_cmd_t            cmd,
  input  logic [ckc_pkg::COLOR_W-1:0]  key_red,
  input  logic [ckc_pkg::COLOR_W-1:0]  key_green,
  input  logic [ckc_pkg::COLOR_W-1:0]  key_blue,
  input  logic [ckc_pkg::COLOR_W-1:0]  pix_red,
  input  logic [ckc_pkg::COLOR_W-1:0]  pix_green,
  input  logic [ckc_pkg::COLOR_W-1:0]  pix_blue,
  input  logic [ckc_pkg::POS_W-1:0]    pos_x,
  input  logic [ckc_pkg::POS_W-1:0]    pos_y,
  output logic [ckc_pkg::POS_W-1:0]    center_x,
  output logic [ckc_pkg::POS_W-1:0]    center_y,
  output logic [ckc_pkg::CNT_W-1:0]    match_count,
  output logic                         found,
  input  logic                         rst_n
);

  localparam int PW = ckc_pkg::POS_W;
  localparam int CW = ckc_pkg::CNT_W;
  localparam int SW = ckc_pkg::SUM_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] sx_r, sx_nxt;
  logic [SW-1:0] sy_r, sy_nxt;
  logic          hit;

  logic [CW-1:0] dcnt_r;
  logic [CW-1:0] remx_r, remy_r, remx_nxt, remy_nxt;
  logic [PW-1:0] shx_r, shy_r;
  logic [CW:0]   trx, try_w;
  logic          qx, qy;

  logic [PW-1:0] cx_r, cy_r;
  logic [CW-1:0] mc_r;
  logic          found_r;

  assign hit = (pix_red == key_red) && (pix_green == key_green) && (pix_blue == key_blue)
            && ({(ckc_pkg::DIM_W - PW)'(0), pos_x} < ckc_pkg::DIM_LIMIT)
            && ({(ckc_pkg::DIM_W - PW)'(0), pos_y} < ckc_pkg::DIM_LIMIT)
            && (cnt_r < ckc_pkg::HIT_CAP);

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    if (hit) begin
      cnt_nxt = cnt_r + 1'b1;
      sx_nxt  = sx_r + SW'(pos_x);
      sy_nxt  = sy_r + SW'(pos_y);
    end
  end

  // Accumulators count only within a frame; clearing is part of control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
    end else if (cmd.acc) begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
    end
  end

  // Restoring division, one quotient bit per step. The upper dividend bits
  // are already below the divisor because the mean fits in PW bits.
  assign trx   = {remx_r, shx_r[PW-1]};
  assign try_w = {remy_r, shy_r[PW-1]};
  assign qx    = (trx >= {1'b0, dcnt_r});
  assign qy    = (try_w >= {1'b0, dcnt_r});
  assign remx_nxt = qx ? CW'(trx - {1'b0, dcnt_r}) : trx[CW-1:0];
  assign remy_nxt = qy ? CW'(try_w - {1'b0, dcnt_r}) : try_w[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dcnt_r <= cnt_nxt;
      remx_r <= sx_nxt[SW-1:PW];
      remy_r <= sy_nxt[SW-1:PW];
      shx_r  <= sx_nxt[PW-1:0];
      shy_r  <= sy_nxt[PW-1:0];
    end else if (cmd.step) begin
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      shx_r  <= {shx_r[PW-2:0], qx};
      shy_r  <= {shy_r[PW-2:0], qy};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r <= (dcnt_r != '0);
      mc_r    <= dcnt_r;
      cx_r    <= (dcnt_r != '0) ? shx_r : '0;
      cy_r    <= (dcnt_r != '0) ? shy_r : '0;
    end
  end

  assign center_x    = cx_r;
  assign center_y    = cy_r;
  assign match_count = mc_r;
  assign found       = found_r;

endmodule

/* hdl/color_key_centroid.sv */
// Top level of the color key centroid block: configuration registers and
// the controller and datapath instances. Depends on ckc_pkg, ckc_ctrl, ckc_dp.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_pix_red/green/blue, in_pos_x/y, in_frame_end
//   out_      output     out_valid / out_ready  out_center_x/y, out_match_count, out_found
//   config    input      APB write, pready = 1  key_red, key_green, key_blue at 0x0/0x4/0x8
//
// Pixels are taken one per clock cycle while the block accumulates.
// A transfer that carries frame_end starts a divide of DIV_STEPS steps,
// one quotient bit per cycle in the two restoring dividers that run side by side,
// then a load of the output register; in_ready stays low until that load is done.
// A result that waits on out_ready holds the block after its next frame ends.
// Reset (rst_n, synchronous, active low) clears the keys, the accumulators,
// the controller state and out_valid.
module color_key_centroid (
  input  logic                               clk,
  input  logic                               rst_n,
  // Pixel input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ckc_pkg::COLOR_W-1:0]        in_pix_red,
  input  logic [ckc_pkg::COLOR_W-1:0]        in_pix_green,
  input  logic [ckc_pkg::COLOR_W-1:0]        in_pix_blue,
  input  logic [ckc_pkg::POS_W-1:0]          in_pos_x,
  input  logic [ckc_pkg::POS_W-1:0]          in_pos_y,
  input  logic                               in_frame_end,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ckc_pkg::POS_W-1:0]          out_center_x,
  output logic [ckc_pkg::POS_W-1:0]          out_center_y,
  output logic [ckc_pkg::CNT_W-1:0]          out_match_count,
  output logic                               out_found,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ckc_pkg::ADDR_W-1:0]         paddr,
  input  logic [ckc_pkg::DATA_W-1:0]         pwdata,
  output logic [ckc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  logic [ckc_pkg::COLOR_W-1:0] key_red_r, key_green_r, key_blue_r;
  logic                        wr_en;
  ckc_pkg::reg_idx_t           reg_idx;
  ckc_pkg::ckc_cmd_t           cmd;

  // The port never stalls, so every access phase completes without wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = ckc_pkg::reg_idx_t'(paddr[3:2]);

  // Key registers. A write to an address past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= '0;
      key_green_r <= '0;
      key_blue_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ckc_pkg::REG_KEY_RED:   key_red_r   <= pwdata[ckc_pkg::COLOR_W-1:0];
        ckc_pkg::REG_KEY_GREEN: key_green_r <= pwdata[ckc_pkg::COLOR_W-1:0];
        ckc_pkg::REG_KEY_BLUE:  key_blue_r  <= pwdata[ckc_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the key bytes zero extended; unused addresses read zero.
  always_comb begin
    unique case (reg_idx)
      ckc_pkg::REG_KEY_RED:   prdata = ckc_pkg::DATA_W'(key_red_r);
      ckc_pkg::REG_KEY_GREEN: prdata = ckc_pkg::DATA_W'(key_green_r);
      ckc_pkg::REG_KEY_BLUE:  prdata = ckc_pkg::DATA_W'(key_blue_r);
      default:                prdata = '0;
    endcase
  end

  // The controller sequences accumulate, divide and output load.
  ckc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  // The datapath holds the sums, the divider and the result register.
  ckc_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .key_red     (key_red_r),
    .key_green   (key_green_r),
    .key_blue    (key_blue_r),
    .pix_red     (in_pix_red),
    .pix_green   (in_pix_green),
    .pix_blue    (in_pix_blue),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .center_x    (out_center_x),
    .center_y    (out_center_y),
    .match_count (out_match_count),
    .found       (out_found),
    .rst_n       (rst_n)
  );

endmodule

/* verif/tb_color_key_centroid.sv */
// Self-checking testbench for color_key_centroid: pixel frames go in, centroid results are
// checked field by field against a predictor that runs inside the testbench.
// Depends on ckc_pkg and the color_key_centroid RTL.
module tb_color_key_centroid;

  localparam int RAND_PHASES  = 12;
  localparam int PHASE_PIXELS = 82;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [ckc_pkg::COLOR_W-1:0] red;
    logic [ckc_pkg::COLOR_W-1:0] green;
    logic [ckc_pkg::COLOR_W-1:0] blue;
    logic [ckc_pkg::POS_W-1:0]   x;
    logic [ckc_pkg::POS_W-1:0]   y;
    logic                        last;
  } pixel_t;

  typedef struct packed {
    logic [ckc_pkg::POS_W-1:0] cx;
    logic [ckc_pkg::POS_W-1:0] cy;
    logic [ckc_pkg::CNT_W-1:0] cnt;
    logic                      found;
  } centroid_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [ckc_pkg::COLOR_W-1:0] in_pix_red = '0;
  logic [ckc_pkg::COLOR_W-1:0] in_pix_green = '0;
  logic [ckc_pkg::COLOR_W-1:0] in_pix_blue = '0;
  logic [ckc_pkg::POS_W-1:0]   in_pos_x = '0;
  logic [ckc_pkg::POS_W-1:0]   in_pos_y = '0;
  logic                        in_frame_end = 1'b0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ckc_pkg::POS_W-1:0]   out_center_x;
  logic [ckc_pkg::POS_W-1:0]   out_center_y;
  logic [ckc_pkg::CNT_W-1:0]   out_match_count;
  logic                        out_found;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ckc_pkg::ADDR_W-1:0] paddr = '0;
  logic [ckc_pkg::DATA_W-1:0] pwdata = '0;
  logic [ckc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Pixels waiting to be driven and centroids waiting to come out.
  pixel_t    pix_q[$];
  centroid_t centroid_q[$];

  // Predictor copy of the key registers and the frame accumulators.
  logic [ckc_pkg::COLOR_W-1:0] key_r = '0;
  logic [ckc_pkg::COLOR_W-1:0] key_g = '0;
  logic [ckc_pkg::COLOR_W-1:0] key_b = '0;
  logic [ckc_pkg::CNT_W-1:0]   hit_cnt = '0;
  logic [ckc_pkg::SUM_W-1:0]   col_sum = '0;
  logic [ckc_pkg::SUM_W-1:0]   row_sum = '0;

  logic      calm = 1'b0;
  logic      pix_taken = 1'b0;
  pixel_t    cur;
  centroid_t want;
  int        fail_count = 0;
  int        pixels_sent = 0;
  int        frames_checked = 0;
  int        hits_seen = 0;
  int        key_settings = 1;
  int        stall_cycles = 0;

  color_key_centroid u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pix_red     (in_pix_red),
    .in_pix_green   (in_pix_green),
    .in_pix_blue    (in_pix_blue),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_match_count(out_match_count),
    .out_found      (out_found),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pixel driver. A new pixel is offered only when the previous one has been
  // transferred, so valid and payload hold steady while the block stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pix_taken) begin
      if (pix_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        cur = pix_q.pop_front();
        in_pix_red   <= cur.red;
        in_pix_green <= cur.green;
        in_pix_blue  <= cur.blue;
        in_pos_x     <= cur.x;
        in_pos_y     <= cur.y;
        in_frame_end <= cur.last;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && (calm || $urandom_range(99) >= 20);
  end

  task automatic check_field(input string what, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Monitor and predictor. The result check runs before the pixel update so
  // that a centroid queued on this edge is never compared on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d count=%0d found=%0d",
                   $time, out_center_x, out_center_y, out_match_count, out_found);
          fail_count++;
        end else begin
          want = centroid_q.pop_front();
          check_field("center_x", want.cx, out_center_x);
          check_field("center_y", want.cy, out_center_y);
          check_field("match_count", want.cnt, out_match_count);
          check_field("found", want.found, out_found);
          frames_checked++;
          hits_seen += want.cnt;
        end
      end
      if (in_valid && in_ready) begin
        pixels_sent++;
        // A hit needs all three bytes equal to the key, both coordinates
        // inside the frame, and room left below the hit cap.
        if (in_pix_red == key_r && in_pix_green == key_g && in_pix_blue == key_b &&
            in_pos_x < ckc_pkg::MAX_DIM && in_pos_y < ckc_pkg::MAX_DIM &&
            hit_cnt < ckc_pkg::HIT_CAP) begin
          hit_cnt = hit_cnt + 1'b1;
          col_sum = col_sum + in_pos_x;
          row_sum = row_sum + in_pos_y;
        end
        if (in_frame_end) begin
          if (hit_cnt != 0) begin
            want.cx = ckc_pkg::POS_W'(col_sum / hit_cnt);
            want.cy = ckc_pkg::POS_W'(row_sum / hit_cnt);
          end else begin
            want.cx = '0;
            want.cy = '0;
          end
          want.cnt   = hit_cnt;
          want.found = (hit_cnt != 0);
          centroid_q = {centroid_q, want};
          hit_cnt = '0;
          col_sum = '0;
          row_sum = '0;
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("color_key_centroid: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_key(input ckc_pkg::reg_idx_t idx,
                           input logic [ckc_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      ckc_pkg::REG_KEY_RED:   key_r = data[ckc_pkg::COLOR_W-1:0];
      ckc_pkg::REG_KEY_GREEN: key_g = data[ckc_pkg::COLOR_W-1:0];
      ckc_pkg::REG_KEY_BLUE:  key_b = data[ckc_pkg::COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every pixel is transferred and every centroid has arrived,
  // then gives an unterminated frame time to settle in the block.
  task automatic drain();
    while (pix_q.size() != 0 || in_valid || centroid_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [ckc_pkg::COLOR_W-1:0] r, g, b,
                             input logic [ckc_pkg::POS_W-1:0] x, y, input logic last);
    pixel_t p;
    p     = {r, g, b, x, y, last};
    pix_q = {pix_q, p};
  endtask

  function automatic logic [ckc_pkg::POS_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ckc_pkg::POS_W'($urandom());
  endfunction

  // One frame of len pixels. Pixels hit the key at about hit_pct percent;
  // of the rest a third are near misses with a single color bit flipped.
  task automatic queue_frame(input int len, input logic close, input int hit_pct);
    pixel_t                        p;
    int                            roll;
    int                            flip;
    logic [3*ckc_pkg::COLOR_W-1:0] rgb;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(99);
      rgb  = {key_r, key_g, key_b};
      if (roll >= hit_pct) begin
        if (roll < hit_pct + (100 - hit_pct) / 3) begin
          flip = $urandom_range(3*ckc_pkg::COLOR_W-1);
          rgb[flip] = ~rgb[flip];
        end else begin
          rgb = (3*ckc_pkg::COLOR_W)'($urandom());
        end
      end
      {p.red, p.green, p.blue} = rgb;
      p.x    = pick_pos();
      p.y    = pick_pos();
      p.last = close && (i == len - 1);
      pix_q  = {pix_q, p};
    end
  endtask

  initial begin
    int len;
    int mode;
    int roll;
    int budget;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Keys still at their reset value of black.
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd1, 12'd7, 12'd7, 1'b0);
    queue_pixel(8'd0, 8'd1, 8'd0, 12'd7, 12'd7, 1'b0);
    queue_pixel(8'd1, 8'd0, 8'd0, 12'd7, 12'd7, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 12'd0, 1'b1);
    // A frame with no hit at all reports zeros.
    queue_pixel(8'd255, 8'd255, 8'd255, 12'd0, 12'd0, 1'b1);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b1);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd1, 12'd2, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd2, 12'd2, 1'b1);
    drain();

    // White key; the unmapped register must not disturb it.
    write_key(ckc_pkg::REG_KEY_RED, 32'h0000_00FF);
    write_key(ckc_pkg::REG_KEY_GREEN, 32'hFFFF_FFFF);
    write_key(ckc_pkg::REG_KEY_BLUE, 32'h1234_56FF);
    write_key(ckc_pkg::REG_NONE, 32'hFFFF_FF00);
    key_settings++;
    queue_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 12'd0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd254, 12'd5, 12'd5, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd9, 12'd9, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 12'd4094, 12'd4095, 1'b1);
    repeat (3) queue_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1);
    drain();

    // Back to black through writes whose upper data bits are set.
    write_key(ckc_pkg::REG_KEY_RED, 32'hFFFF_FF00);
    write_key(ckc_pkg::REG_KEY_GREEN, 32'h8000_0000);
    write_key(ckc_pkg::REG_KEY_BLUE, 32'hAAAA_AA00);
    key_settings++;
    queue_pixel(8'd0, 8'd0, 8'd0, 12'd0, 12'd4095, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      write_key(ckc_pkg::REG_KEY_RED, $urandom());
      write_key(ckc_pkg::REG_KEY_GREEN, $urandom());
      write_key(ckc_pkg::REG_KEY_BLUE, $urandom());
      if (ph % 4 == 3) write_key(ckc_pkg::REG_NONE, $urandom());
      key_settings++;
      calm = (ph == 2);
      budget = 0;
      while (budget < PHASE_PIXELS) begin
        roll = $urandom_range(99);
        if (roll < 80) len = $urandom_range(1, 12);
        else if (roll < 95) len = $urandom_range(13, 64);
        else len = $urandom_range(65, 256);
        mode = $urandom_range(9);
        queue_frame(len, 1'b1, (mode == 0) ? 0 : (mode == 1) ? 100 : 45);
        budget += len;
      end
      // Sometimes leave a frame open so its sums carry across the key change.
      if ($urandom_range(1) == 1) queue_frame($urandom_range(1, 8), 1'b0, 45);
    end
    queue_frame($urandom_range(1, 8), 1'b1, 45);
    drain();

    $display("Sent %0d pixels under %0d key settings; checked %0d frames holding %0d hits.",
             pixels_sent, key_settings, frames_checked, hits_seen);
    if (fail_count == 0) begin
      $display("color_key_centroid: match");
    end else begin
      $display("color_key_centroid: mismatch");
    end
    $finish;
  end

endmodule
